[hdl/pffl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_pkg - page frame free list shared types and codes
// Request codes, saturation limits and the control/status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pffl_pkg;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;

	localparam logic [2:0] KIND_USABLE = 3'd0;

	localparam logic [16:0] FREE_MAX  = 17'h1FFFF;
	localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic load;    // item accepted, capture fields
		logic step;    // append one region page
		logic finish;  // complete item, register result
	} cmd_t;

	typedef struct packed {
		logic walk_done;
	} status_t;

endpackage
`default_nettype wire

[hdl/pffl_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_ctrl - page frame free list controller
// Sequences accept, region walk and completion; drives busy and done.
// ----------------------------------------------------------------------------
module pffl_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       req_type,
	input  wire pffl_pkg::status_t status,
	output pffl_pkg::cmd_t        cmd,
	output logic                  busy,
	output logic                  done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (req_type == pffl_pkg::REQ_ADD) ? ST_WALK : ST_EXEC;
				end
			end
			ST_WALK: begin
				if (status.walk_done) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_EXEC: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");

endmodule
`default_nettype wire

[hdl/pffl_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pffl_datapath - page frame free list datapath
// Next-page link memory, list head/tail, free and total counters, region
// walk cursor and result registers.
// ----------------------------------------------------------------------------
module pffl_datapath #(
	parameter int PAGE_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pffl_pkg::cmd_t cmd,
	output pffl_pkg::status_t  status,
	input  wire logic [1:0]    req_type,
	input  wire logic [2:0]    region_kind,
	input  wire logic [15:0]   page_number,
	input  wire logic [16:0]   page_count,
	output logic               ok,
	output logic [15:0]        alloc_page,
	output logic [16:0]        free_pages,
	output logic [23:0]        total_pages
);

	localparam int DEPTH = 1 << PAGE_BITS;
	localparam logic [16:0] LIMIT = (PAGE_BITS < 16) ? 17'(DEPTH) : 17'h10000;

	logic [15:0] mem [0:DEPTH-1];

	logic [1:0]  req_q;
	logic [2:0]  kind_q;
	logic [15:0] page_q;
	logic [16:0] cur_q;
	logic [16:0] rem_q;
	logic [15:0] head_q;
	logic [15:0] tail_q;
	logic        empty_q;
	logic [16:0] free_q;
	logic [23:0] total_q;
	logic [15:0] rd_q;
	logic        ok_q;
	logic [15:0] alloc_q;

	logic                 wr_en;
	logic [PAGE_BITS-1:0] wr_idx;
	logic [15:0]          wr_data;
	logic [24:0]          total_sum;
	logic                 page_in;

	assign total_sum = {1'b0, total_q} + 25'(page_count);
	assign page_in   = ({1'b0, page_q} < LIMIT);

	assign status.walk_done = (rem_q == '0) || (kind_q != pffl_pkg::KIND_USABLE)
		|| (cur_q >= LIMIT);

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = PAGE_BITS'(tail_q);
		wr_data = cur_q[15:0];
		if (cmd.step && !empty_q) begin
			wr_en = 1'b1;
		end else if (cmd.finish && req_q == pffl_pkg::REQ_FREE && page_in && !empty_q) begin
			wr_en   = 1'b1;
			wr_idx  = PAGE_BITS'(page_q);
			wr_data = head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rd_q <= mem[PAGE_BITS'(head_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			kind_q <= region_kind;
			page_q <= page_number;
			cur_q  <= {1'b0, page_number};
			rem_q  <= page_count;
		end else if (cmd.step) begin
			cur_q <= cur_q + 17'd1;
			rem_q <= rem_q - 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			free_q  <= '0;
			total_q <= '0;
			ok_q    <= 1'b0;
			alloc_q <= '0;
		end else begin
			if (cmd.load && req_type == pffl_pkg::REQ_ADD) begin
				total_q <= (total_sum > {1'b0, pffl_pkg::TOTAL_MAX}) ?
					pffl_pkg::TOTAL_MAX : total_sum[23:0];
			end
			if (cmd.step) begin
				if (empty_q) begin
					head_q  <= cur_q[15:0];
					empty_q <= 1'b0;
				end
				tail_q <= cur_q[15:0];
				if (free_q != pffl_pkg::FREE_MAX) begin
					free_q <= free_q + 17'd1;
				end
			end
			if (cmd.finish) begin
				ok_q    <= 1'b1;
				alloc_q <= '0;
				case (req_q)
					pffl_pkg::REQ_ALLOC: begin
						if (empty_q) begin
							ok_q <= 1'b0;
						end else begin
							alloc_q <= head_q;
							if (head_q == tail_q) begin
								empty_q <= 1'b1;
								free_q  <= '0;
							end else begin
								head_q <= rd_q;
								if (free_q != '0) begin
									free_q <= free_q - 17'd1;
								end
							end
						end
					end
					pffl_pkg::REQ_FREE: begin
						if (page_in) begin
							if (empty_q) begin
								tail_q  <= page_q;
								empty_q <= 1'b0;
							end
							head_q <= page_q;
							if (free_q != pffl_pkg::FREE_MAX) begin
								free_q <= free_q + 17'd1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign ok          = ok_q;
	assign alloc_page  = alloc_q;
	assign free_pages  = free_q;
	assign total_pages = total_q;

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (free_q == '0)) else $error("empty list with nonzero free count");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		total_q >= $past(total_q)) else $error("page total decreased");

endmodule
`default_nettype wire

[hdl/page_frame_free_list_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_free_list_core - physical page frame allocator
// Free list of page frames kept as a next-page link table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears for
// exactly one cycle with done high, and that cycle may already accept the next
// item. Allocate, free and unknown requests go from accept through the
// execute state back to idle. Add region walks the region first, appending
// its pages (none for a non-usable or empty region) one page per cycle and
// writing link entries through the single write port of the link memory.
// The link memory holds 2^PAGE_BITS entries and is not cleared; pages at or
// above min(2^PAGE_BITS, 65536) are dropped.
// ----------------------------------------------------------------------------
module page_frame_free_list_core #(
	parameter int PAGE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	input  wire logic [1:0]  req_type,
	input  wire logic [2:0]  region_kind,
	input  wire logic [15:0] page_number,
	input  wire logic [16:0] page_count,
	output logic             ok,
	output logic [15:0]      alloc_page,
	output logic [16:0]      free_pages,
	output logic [23:0]      total_pages
);

	pffl_pkg::cmd_t    cmd;
	pffl_pkg::status_t status;

	pffl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	pffl_datapath #(
		.PAGE_BITS (PAGE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req_type    (req_type),
		.region_kind (region_kind),
		.page_number (page_number),
		.page_count  (page_count),
		.ok          (ok),
		.alloc_page  (alloc_page),
		.free_pages  (free_pages),
		.total_pages (total_pages)
	);

endmodule
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - page frame free list core
// Drives add-region, allocate, free and unknown requests into the core and
// checks each result strobe against a bench free-list predictor or a typed
// row's expected values. A directed table covers reset, the empty list,
// double free, the page-space edge and free-count saturation. Random phases
// with and without sender gaps follow; a fill phase saturates the page total.
// ----------------------------------------------------------------------------
module testbench;

	localparam int PAGE_BITS = 16;
	localparam int unsigned PAGE_LIMIT = (2**PAGE_BITS < 65536) ? 2**PAGE_BITS : 65536;
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int DIR_N = 24;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [1:0]  req;
		logic [2:0]  kind;
		logic [15:0] page;
		logic [16:0] count;
	} pf_req_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] page;
		logic [16:0] free_cnt;
		logic [23:0] total;
	} pf_res_t;

	typedef struct packed {
		pf_req_t rq;
		logic    typed;
		pf_res_t res;
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  req_type = '0;
	logic [2:0]  region_kind = '0;
	logic [15:0] page_number = '0;
	logic [16:0] page_count = '0;
	logic        busy;
	logic        done;
	logic        ok;
	logic [15:0] alloc_page;
	logic [16:0] free_pages;
	logic [23:0] total_pages;

	// free-list model state
	logic [15:0] link_tab [PAGE_LIMIT];
	bit          link_set [PAGE_LIMIT];
	logic [15:0] lst_head = '0;
	logic [15:0] lst_tail = '0;
	bit          lst_empty = 1'b1;
	logic [16:0] free_cnt = '0;
	logic [23:0] page_total = '0;

	pf_res_t     pending_res [$];
	logic [15:0] handed_out [$];
	int          err_cnt = 0;

	// typed rows: after reset, empty list, saturation extremes
	dir_row_t dir_tab [DIR_N] = '{
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b1, '{1'b0, 16'd0, 17'd0, 24'd0}},
		'{'{pffl_pkg::REQ_FREE,  3'd0, 16'd100, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_FREE,  3'd0, 16'd7, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_FREE,  3'd0, 16'd8, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_FREE,  3'd0, 16'd8, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_FREE,  3'd0, 16'd7, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b1, '{1'b0, 16'd0, 17'd0, 24'd0}},
		'{'{pffl_pkg::REQ_ADD,   3'd0, 16'd5, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ADD,   3'd7, 16'd65535, 17'd65536}, 1'b1,
			'{1'b1, 16'd0, 17'd0, 24'd65536}},
		'{'{pffl_pkg::REQ_ADD,   3'd0, 16'd65530, 17'd10}, 1'b0, '0},
		'{'{REQ_NONE,            3'd7, 16'd65535, 17'h1FFFF}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ADD,   3'd0, 16'd0, 17'd65536}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ADD,   3'd0, 16'd0, 17'd65536}, 1'b1,
			'{1'b1, 16'd0, pffl_pkg::FREE_MAX, 24'd196618}},
		'{'{pffl_pkg::REQ_FREE,  3'd0, 16'd65535, 17'd0}, 1'b1,
			'{1'b1, 16'd0, pffl_pkg::FREE_MAX, 24'd196618}},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b1,
			'{1'b1, 16'd65535, 17'd0, 24'd196618}},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b1,
			'{1'b0, 16'd0, 17'd0, 24'd196618}},
		'{'{pffl_pkg::REQ_FREE,  3'd0, 16'd0, 17'd0}, 1'b0, '0},
		'{'{pffl_pkg::REQ_ALLOC, 3'd0, 16'd0, 17'd0}, 1'b0, '0}
	};

	page_frame_free_list_core #(
		.PAGE_BITS(PAGE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.req_type(req_type),
		.region_kind(region_kind),
		.page_number(page_number),
		.page_count(page_count),
		.ok(ok),
		.alloc_page(alloc_page),
		.free_pages(free_pages),
		.total_pages(total_pages)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("testbench: errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic void count_up();
		if (free_cnt != pffl_pkg::FREE_MAX)
			free_cnt++;
	endfunction

	function automatic void append_page(input logic [15:0] pg);
		if (lst_empty) begin
			lst_head = pg;
			lst_empty = 1'b0;
		end else begin
			link_tab[lst_tail] = pg;
			link_set[lst_tail] = 1'b1;
		end
		lst_tail = pg;
		count_up();
	endfunction

	function automatic pf_res_t step_list(input pf_req_t rq);
		pf_res_t     res;
		logic [24:0] sum;
		int unsigned pg;
		res = '0;
		res.ok = 1'b1;
		case (rq.req)
		pffl_pkg::REQ_ADD: begin
			sum = {1'b0, page_total} + 25'(rq.count);
			page_total = (sum > 25'(pffl_pkg::TOTAL_MAX)) ? pffl_pkg::TOTAL_MAX : sum[23:0];
			if (rq.kind == pffl_pkg::KIND_USABLE) begin
				for (int unsigned j = 0; j < rq.count; j++) begin
					pg = rq.page + j;
					if (pg >= PAGE_LIMIT)
						break;
					append_page(pg[15:0]);
				end
			end
		end
		pffl_pkg::REQ_ALLOC: begin
			if (lst_empty) begin
				res.ok = 1'b0;
			end else begin
				res.page = lst_head;
				if (lst_head == lst_tail) begin
					lst_empty = 1'b1;
					free_cnt = '0;
				end else begin
					lst_head = link_tab[lst_head];
					if (free_cnt != 0)
						free_cnt--;
				end
			end
		end
		pffl_pkg::REQ_FREE: begin
			if (rq.page < PAGE_LIMIT) begin
				if (lst_empty) begin
					lst_tail = rq.page;
					lst_empty = 1'b0;
				end else begin
					link_tab[rq.page] = lst_head;
					link_set[rq.page] = 1'b1;
				end
				lst_head = rq.page;
				count_up();
			end
		end
		default: ;
		endcase
		res.free_cnt = free_cnt;
		res.total = page_total;
		return res;
	endfunction

	function automatic pf_req_t pick_req(input bit fill);
		pf_req_t     rq;
		int unsigned r;
		int unsigned sel;
		rq.req = pffl_pkg::REQ_ALLOC;
		rq.kind = 3'($urandom_range(0, 7));
		rq.page = 16'($urandom);
		rq.count = 17'($urandom_range(0, 65536));
		r = $urandom_range(0, 99);
		if (fill && r < 95) begin
			rq.req = pffl_pkg::REQ_ADD;
			rq.kind = 3'($urandom_range(1, 7));
			rq.count = 17'h10000;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				rq.req = pffl_pkg::REQ_ALLOC;
			end else if (r < 57) begin
				rq.req = pffl_pkg::REQ_FREE;
				if (handed_out.size() != 0 && $urandom_range(0, 99) < 70)
					rq.page = handed_out[$urandom_range(0, handed_out.size() - 1)];
			end else if (r < 92) begin
				rq.req = pffl_pkg::REQ_ADD;
				if ($urandom_range(0, 3) != 0)
					rq.kind = pffl_pkg::KIND_USABLE;
				sel = $urandom_range(0, 99);
				if (sel < 5)
					rq.count = '0;
				else if (sel < 85)
					rq.count = 17'($urandom_range(1, 16));
				else if (sel < 98)
					rq.count = 17'($urandom_range(17, 300));
				if ($urandom_range(0, 99) < 15)
					rq.page = 16'hFFFF - 16'($urandom_range(0, 19));
			end else begin
				rq.req = REQ_NONE;
			end
		end
		// never walk into a link entry that was never written
		if (rq.req == pffl_pkg::REQ_ALLOC && !lst_empty && lst_head != lst_tail
				&& !link_set[lst_head])
			rq.req = pffl_pkg::REQ_FREE;
		return rq;
	endfunction

	task automatic send_req(input pf_req_t rq, input logic typed, input pf_res_t typed_res,
			input int gap);
		pf_res_t pred;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		req_type <= rq.req;
		region_kind <= rq.kind;
		page_number <= rq.page;
		page_count <= rq.count;
		do
			@(posedge clk);
		while (busy);
		pred = step_list(rq);
		pending_res.push_back(typed ? typed_res : pred);
		if (rq.req == pffl_pkg::REQ_ALLOC && pred.ok) begin
			handed_out.push_back(pred.page);
			if (handed_out.size() > 32)
				void'(handed_out.pop_front());
		end
	endtask

	task automatic drain_results();
		while (pending_res.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		pf_res_t want;
		if (arst_n && done) begin
			if (pending_res.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = pending_res.pop_front();
				if (ok !== want.ok)
					report_mismatch($sformatf("ok %b, want %b", ok, want.ok));
				if (alloc_page !== want.page)
					report_mismatch($sformatf("alloc_page %0d, want %0d",
						alloc_page, want.page));
				if (free_pages !== want.free_cnt)
					report_mismatch($sformatf("free_pages %0d, want %0d",
						free_pages, want.free_cnt));
				if (total_pages !== want.total)
					report_mismatch($sformatf("total_pages %0d, want %0d",
						total_pages, want.total));
			end
		end
	end

	initial begin
		int idle_pct [5] = '{0, 47, 24, 0, 24};
		int gap;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].res, 0);
		@(negedge clk);
		start <= 1'b0;
		drain_results();

		// phase 4 fills the page total up to saturation
		for (int ph = 0; ph < 5; ph++) begin
			for (int i = 0; i < ((ph == 4) ? 280 : 85); i++) begin
				gap = 0;
				while (gap < 20 && $urandom_range(0, 99) < idle_pct[ph])
					gap++;
				send_req(pick_req(ph == 4), 1'b0, '0, gap);
			end
			@(negedge clk);
			start <= 1'b0;
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pending_res.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

[sim.f]
hdl/pffl_pkg.sv
hdl/pffl_ctrl.sv
hdl/pffl_datapath.sv
hdl/page_frame_free_list_core.sv
sim/testbench.sv
